/* rtl/nau_pkg.sv */
`timescale 1ns / 1ps
// Package for the neural activation unit: mode codes, register indexes,
// the control group that travels down the pipeline, and the elaboration-time
// functions that build the sigmoid table. Depends on nothing.
package nau_pkg;

	// Activation function codes held in the act_mode register.
	localparam logic [2:0] MODE_LINEAR  = 3'd0;
	localparam logic [2:0] MODE_SIGMOID = 3'd1;
	localparam logic [2:0] MODE_TANH    = 3'd2;
	localparam logic [2:0] MODE_RELU    = 3'd3;
	localparam logic [2:0] MODE_SWISH   = 3'd4;
	localparam logic [2:0] MODE_LEAKY   = 3'd5;

	// Register indexes, taken from address bit 2.
	localparam logic REG_ACT_MODE   = 1'b0;
	localparam logic REG_LEAK_SLOPE = 1'b1;

	localparam int          MODE_W           = 3;
	localparam int          SLOPE_W          = 16;
	localparam logic [15:0] LEAK_SLOPE_RESET = 16'd655;

	// Sigmoid values are unsigned Q0.16 in the range 0 to 1.0 inclusive.
	localparam int          SIG_W   = 17;
	localparam logic [16:0] SIG_ONE = 17'h10000;

	// Control group that rides along with each sample.
	typedef struct packed {
		logic                valid;
		logic                last;
		logic [MODE_W-1:0]   mode;
	} nau_ctl_t;

	// Restoring division, used only while the table is built at elaboration.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Table point k: sigmoid(k * step) in Q0.16, where step is the table
	// spacing in Q32. exp(-step) comes from a truncated Taylor sum, and
	// exp(-k * step) from repeated rounded products.
	function automatic logic [16:0] sig_point(input logic [63:0] step, input int k);
		logic [63:0] term;
		logic [63:0] esum;
		logic [63:0] epow;
		logic [63:0] den;
		logic [63:0] prod;
		term = 64'd1 << 32;
		esum = 64'd1 << 32;
		epow = 64'd1 << 32;
		for (int n = 1; n <= 24; n++) begin
			prod = term * step;
			term = udiv64(prod >> 32, 64'(n));
			if ((n & 1) == 1) begin
				esum = esum - term;
			end else begin
				esum = esum + term;
			end
		end
		for (int j = 1; j <= k; j++) begin
			epow = (epow * esum + (64'd1 << 31)) >> 32;
		end
		den = (64'd1 << 32) + epow;
		return 17'(udiv64((64'd1 << 48) + (den >> 1), den));
	endfunction

endpackage

/* rtl/nau_sigmoid.sv */
`timescale 1ns / 1ps
// Four-stage sigmoid pipeline: magnitude and range check, table index,
// table lookup, and linear interpolation with mirroring for negative inputs.
// Depends on nau_pkg for the control group and the table builder.
module nau_sigmoid #(
	parameter int DATA_WIDTH        = 16,
	parameter int FRAC_BITS         = 8,
	parameter int SIG_TABLE_ENTRIES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  nau_pkg::nau_ctl_t                    ctl_in,
	input  logic signed [DATA_WIDTH:0]           v_in,
	input  logic signed [DATA_WIDTH-1:0]         pass_in,
	output nau_pkg::nau_ctl_t                    ctl_out,
	output logic signed [DATA_WIDTH-1:0]         pass_out,
	output logic [nau_pkg::SIG_W-1:0]            sig_out
);

	localparam int AW = DATA_WIDTH + 1;
	localparam int IW = $clog2(SIG_TABLE_ENTRIES + 1);
	localparam int RW = FRAC_BITS + 3;
	localparam int PW = AW + IW + RW;
	localparam int CW = ((AW > RW + 1) ? AW : RW + 1) + 1;
	localparam int MW = nau_pkg::SIG_W + RW;
	localparam logic [63:0]   STEP      = (64'd8 << 32) / SIG_TABLE_ENTRIES;
	localparam logic [CW-1:0] SIG_LIMIT = CW'(64'd8 << FRAC_BITS);

	// Constant sigmoid table over [0, 8], one more point than intervals.
	logic [nau_pkg::SIG_W-1:0] sig_tab [SIG_TABLE_ENTRIES+1];

	for (genvar k = 0; k <= SIG_TABLE_ENTRIES; k++) begin : g_tab
		localparam logic [nau_pkg::SIG_W-1:0] POINT = nau_pkg::sig_point(STEP, k);
		assign sig_tab[k] = POINT;
	end

	nau_pkg::nau_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [DATA_WIDTH-1:0] pass_s1, pass_s2, pass_s3, pass_s4;
	logic [AW-1:0]               mag_s1;
	logic                        neg_s1, neg_s2, neg_s3;
	logic                        sat_s1, sat_s2, sat_s3;
	logic [IW-1:0]               idx_s2;
	logic [RW-1:0]               rem_s2, rem_s3;
	logic [nau_pkg::SIG_W-1:0]   lo_s3, diff_s3, sig_s4;

	logic [AW-1:0]             mag;
	logic [PW-1:0]             pos;
	logic [nau_pkg::SIG_W-1:0] lo_val, hi_val;
	logic [MW-1:0]             interp;
	logic [nau_pkg::SIG_W-1:0] sig_mag;

	// Valid bits and control fields move down the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Stage 1: magnitude of the argument and the saturation check.
	always_comb begin
		mag = v_in[AW-1] ? AW'(-v_in) : AW'(v_in);
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag;
		neg_s1  <= v_in[AW-1];
		sat_s1  <= CW'(mag) >= SIG_LIMIT;
		pass_s1 <= pass_in;
	end

	// Stage 2: scale to table position; the interval is a power of two.
	always_comb begin
		pos = PW'(mag_s1) * PW'(SIG_TABLE_ENTRIES);
	end

	always_ff @(posedge clk) begin
		idx_s2  <= sat_s1 ? '0 : pos[RW +: IW];
		rem_s2  <= pos[RW-1:0];
		neg_s2  <= neg_s1;
		sat_s2  <= sat_s1;
		pass_s2 <= pass_s1;
	end

	// Stage 3: read the two neighboring table points.
	always_comb begin
		lo_val = sig_tab[idx_s2];
		hi_val = sig_tab[idx_s2 + IW'(1)];
	end

	always_ff @(posedge clk) begin
		lo_s3   <= lo_val;
		diff_s3 <= (hi_val >= lo_val) ? hi_val - lo_val : '0;
		rem_s3  <= rem_s2;
		neg_s3  <= neg_s2;
		sat_s3  <= sat_s2;
		pass_s3 <= pass_s2;
	end

	// Stage 4: interpolate, saturate, and mirror for negative arguments.
	always_comb begin
		interp  = MW'(diff_s3) * MW'(rem_s3);
		sig_mag = sat_s3 ? nau_pkg::SIG_ONE : lo_s3 + interp[RW +: nau_pkg::SIG_W];
	end

	always_ff @(posedge clk) begin
		sig_s4  <= neg_s3 ? nau_pkg::SIG_ONE - sig_mag : sig_mag;
		pass_s4 <= pass_s3;
	end

	assign ctl_out  = ctl_s4;
	assign pass_out = pass_s4;
	assign sig_out  = sig_s4;

`ifndef SYNTHESIS
	// A saturated argument gives exactly zero or one.
	a_sat_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.valid && sat_s3) |=> (sig_s4 == '0 || sig_s4 == nau_pkg::SIG_ONE))
		else $error("saturated sigmoid is not 0 or 1");

	// The interpolated value never passes one.
	a_sig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid |=> (sig_s4 <= nau_pkg::SIG_ONE))
		else $error("sigmoid value above one");

	// Negative arguments give at most one half.
	a_neg_half: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.valid && neg_s3) |=> (sig_s4 <= (nau_pkg::SIG_ONE >> 1)))
		else $error("sigmoid of a negative argument above one half");
`endif

endmodule

/* rtl/neural_activation_unit.sv */
`timescale 1ns / 1ps
// Neural activation unit top level: configuration registers, the sigmoid
// pipeline instance, and the final mode select, multiply and saturation.
// Depends on nau_pkg and nau_sigmoid.

// The unit takes one sample in every clock cycle and never raises busy.
// Each accepted sample gives exactly one result. The result is on the ports,
// marked by done, for a single cycle, and it transfers at the edge that ends
// that cycle. The receiver cannot hold a result off. Results come out in the
// order that samples went in. Six register stages set the latency. Four of
// them are the sigmoid table lookup and interpolation. The last two are the
// mode multiply, and the rounding and saturation.
// act_mode and leak_slope should be written only while no sample is in flight.
module neural_activation_unit #(
	parameter int DATA_WIDTH        = 16,
	parameter int FRAC_BITS         = 8,
	parameter int SIG_TABLE_ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] x_in,
	input  logic                         last_in,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] y_out,
	output logic                         last_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int AW  = DATA_WIDTH + 1;
	localparam int PRW = DATA_WIDTH + nau_pkg::SIG_W + 1;
	localparam int SW  = nau_pkg::SIG_W + FRAC_BITS + 2;
	localparam int YW  = DATA_WIDTH + FRAC_BITS + 18;
	localparam logic signed [YW-1:0] Y_MAX =
		{{(YW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [YW-1:0] Y_MIN =
		{{(YW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [YW-1:0] Y_UNIT = YW'(64'd1 << FRAC_BITS);

	logic [nau_pkg::MODE_W-1:0]  act_mode_q;
	logic [nau_pkg::SLOPE_W-1:0] leak_slope_q;

	// Configuration port; low address bits are ignored.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q   <= nau_pkg::MODE_LINEAR;
			leak_slope_q <= nau_pkg::LEAK_SLOPE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				nau_pkg::REG_ACT_MODE: begin
					act_mode_q <= pwdata[nau_pkg::MODE_W-1:0];
				end
				nau_pkg::REG_LEAK_SLOPE: begin
					leak_slope_q <= pwdata[nau_pkg::SLOPE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			nau_pkg::REG_ACT_MODE:   prdata = 32'(act_mode_q);
			nau_pkg::REG_LEAK_SLOPE: prdata = 32'(leak_slope_q);
			default:                 prdata = '0;
		endcase
	end

	// Intake: tanh needs sigmoid of twice the sample, kept one bit wider.
	nau_pkg::nau_ctl_t        ctl_in;
	logic signed [AW-1:0]     sig_arg;

	assign busy = 1'b0;

	always_comb begin
		ctl_in.valid = start && !busy;
		ctl_in.last  = last_in;
		ctl_in.mode  = act_mode_q;
		sig_arg      = (act_mode_q == nau_pkg::MODE_TANH) ? {x_in, 1'b0} : {x_in[DATA_WIDTH-1], x_in};
	end

	nau_pkg::nau_ctl_t            ctl_s4;
	logic signed [DATA_WIDTH-1:0] x_s4;
	logic [nau_pkg::SIG_W-1:0]    sig_s4;

	nau_sigmoid #(
		.DATA_WIDTH        (DATA_WIDTH),
		.FRAC_BITS         (FRAC_BITS),
		.SIG_TABLE_ENTRIES (SIG_TABLE_ENTRIES)
	) u_sigmoid (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_in),
		.v_in     (sig_arg),
		.pass_in  (x_in),
		.ctl_out  (ctl_s4),
		.pass_out (x_s4),
		.sig_out  (sig_s4)
	);

	// Stage 5: pick the multiplier operand and form the direct results.
	nau_pkg::nau_ctl_t         ctl_s5;
	logic signed [PRW-1:0]     prod_s5;
	logic signed [YW-1:0]      cand_s5;
	logic                      use_prod_s5;

	logic [nau_pkg::SIG_W-1:0] mul_op;
	logic [SW-1:0]             sig_sc, tanh_sc;
	logic signed [YW-1:0]      sig_y, tanh_y, x_y, cand;
	logic                      use_prod;

	always_comb begin
		mul_op   = (ctl_s4.mode == nau_pkg::MODE_SWISH) ? sig_s4 : nau_pkg::SIG_W'(leak_slope_q);
		sig_sc   = (SW'(sig_s4) << FRAC_BITS) + SW'(32768);
		tanh_sc  = (SW'(sig_s4) << (FRAC_BITS + 1)) + SW'(32768);
		sig_y    = YW'(signed'({1'b0, sig_sc[SW-1:16]}));
		tanh_y   = YW'(signed'({1'b0, tanh_sc[SW-1:16]})) - Y_UNIT;
		x_y      = YW'(x_s4);
		use_prod = 1'b0;
		case (ctl_s4.mode)
			nau_pkg::MODE_SIGMOID: cand = sig_y;
			nau_pkg::MODE_TANH:    cand = tanh_y;
			nau_pkg::MODE_RELU:    cand = x_s4[DATA_WIDTH-1] ? '0 : x_y;
			nau_pkg::MODE_SWISH: begin
				cand     = x_y;
				use_prod = 1'b1;
			end
			nau_pkg::MODE_LEAKY: begin
				cand     = x_y;
				use_prod = x_s4[DATA_WIDTH-1];
			end
			default:               cand = x_y;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else begin
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s5     <= PRW'(x_s4) * PRW'(signed'({1'b0, mul_op}));
		cand_s5     <= cand;
		use_prod_s5 <= use_prod;
	end

	// Stage 6: round the Q16 product half up, then saturate to the port width.
	logic signed [PRW-1:0] prod_rnd;
	logic signed [YW-1:0]  full_y;

	always_comb begin
		prod_rnd = (prod_s5 + PRW'(32768)) >>> 16;
		full_y   = use_prod_s5 ? YW'(prod_rnd) : cand_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_out <= ctl_s5.last;
		if (full_y > Y_MAX) begin
			y_out <= Y_MAX[DATA_WIDTH-1:0];
		end else if (full_y < Y_MIN) begin
			y_out <= Y_MIN[DATA_WIDTH-1:0];
		end else begin
			y_out <= full_y[DATA_WIDTH-1:0];
		end
	end

`ifndef SYNTHESIS
	// Every accepted sample comes out as a done strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted sample did not complete in six cycles");

	// No result appears without a matching accepted sample.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without a matching sample");

	// ReLU never gives a negative result.
	a_relu_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s5.valid && ctl_s5.mode == nau_pkg::MODE_RELU) |=> !y_out[DATA_WIDTH-1])
		else $error("negative ReLU result");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for neural_activation_unit: a directed table followed by
// randomized samples under several register settings and sender idle rates.
// Depends on nau_pkg and the unit's RTL; computes its own expected results.
module tb;

	localparam int              LATENCY        = 6;
	localparam int              WATCHDOG_LIMIT = 2000;
	localparam int              SEGMENTS       = 16;
	localparam int              SEG_ITEMS      = 50;
	localparam int              FRAC           = 8;
	localparam int              TABLE_POINTS   = 256;
	localparam longint unsigned SIG_SPAN       = 64'd8 << FRAC;
	localparam longint          Q16_ONE        = 65536;
	localparam longint          Y_MAX          = 32767;
	localparam longint          Y_MIN          = -32768;

	// Mode codes that the unit does not define; they act as linear.
	localparam logic [2:0] MODE_UNDEF6 = 3'd6;
	localparam logic [2:0] MODE_UNDEF7 = 3'd7;

	typedef struct packed {
		logic signed [15:0] y;
		logic               last;
	} act_result_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [15:0]        slope;
		logic signed [15:0] x;
		logic               last;
		logic               known;
		logic signed [15:0] y;
	} stim_row_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic signed [15:0] x_in     = '0;
	logic               last_in  = 1'b0;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [2:0]         paddr    = '0;
	logic [31:0]        pwdata   = '0;
	logic               busy;
	logic               done;
	logic signed [15:0] y_out;
	logic               last_out;
	logic [31:0]        prdata;
	logic               pready;

	longint unsigned sig_table [0:TABLE_POINTS];
	act_result_t     pending_outputs [$];
	stim_row_t       dir_rows [$];
	logic [2:0]      cur_mode  = nau_pkg::MODE_LINEAR;
	logic [15:0]     cur_slope = nau_pkg::LEAK_SLOPE_RESET;
	int              err_count       = 0;
	int              samples_sent    = 0;
	int              results_checked = 0;
	int              idle_pct        = 0;
	int              stall_count     = 0;

	neural_activation_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.x_in     (x_in),
		.last_in  (last_in),
		.done     (done),
		.y_out    (y_out),
		.last_out (last_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// Sigmoid points over [0,8] in Q0.16: exp(-step) from a truncated Taylor
	// sum in Q32, then powers of it by rounded products.
	task automatic build_sig_table();
		longint unsigned step;
		longint unsigned term;
		longint unsigned esum;
		longint unsigned epow;
		longint unsigned den;
		step = (64'd8 << 32) / TABLE_POINTS;
		term = 64'd1 << 32;
		esum = 64'd1 << 32;
		epow = 64'd1 << 32;
		for (int n = 1; n <= 24; n++) begin
			term = ((term * step) >> 32) / longint'(n);
			if (n % 2 == 1) begin
				esum = esum - term;
			end else begin
				esum = esum + term;
			end
		end
		for (int k = 0; k <= TABLE_POINTS; k++) begin
			if (k > 0) begin
				epow = (epow * esum + (64'd1 << 31)) >> 32;
			end
			den = (64'd1 << 32) + epow;
			sig_table[k] = ((64'd1 << 48) + den / 2) / den;
		end
	endtask

	// Sigmoid of a Q.8 value in Q0.16, mirrored for negative input.
	function automatic longint sigmoid_q16(longint v);
		longint unsigned mag;
		longint unsigned pos;
		longint unsigned idx;
		longint unsigned frac;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned s;
		mag = (v < 0) ? -v : v;
		if (mag >= SIG_SPAN) begin
			s = Q16_ONE;
		end else begin
			pos  = mag * TABLE_POINTS;
			idx  = pos / SIG_SPAN;
			frac = pos % SIG_SPAN;
			lo   = sig_table[int'(idx)];
			hi   = sig_table[int'(idx) + 1];
			s    = lo + ((hi >= lo) ? (hi - lo) : 0) * frac / SIG_SPAN;
		end
		if (v < 0) begin
			s = Q16_ONE - s;
		end
		return longint'(s);
	endfunction

	// Expected activation of one sample under the given register values.
	function automatic logic signed [15:0] activate(logic [2:0] mode, logic [15:0] slope,
			logic signed [15:0] x);
		longint xv;
		longint y;
		longint m;
		xv = x;
		m  = longint'({48'd0, slope});
		case (mode)
			nau_pkg::MODE_SIGMOID: y = ((sigmoid_q16(xv) << FRAC) + 32768) >>> 16;
			nau_pkg::MODE_TANH:    y = (((2 * sigmoid_q16(2 * xv)) << FRAC) + 32768) >>> 16;
			nau_pkg::MODE_RELU:    y = (xv >= 0) ? xv : 0;
			nau_pkg::MODE_SWISH:   y = (xv * sigmoid_q16(xv) + 32768) >>> 16;
			nau_pkg::MODE_LEAKY:   y = (xv >= 0) ? xv : ((xv * m + 32768) >>> 16);
			default:               y = xv;
		endcase
		if (mode == nau_pkg::MODE_TANH) begin
			y = y - (64'sd1 <<< FRAC);
		end
		if (y > Y_MAX) y = Y_MAX;
		if (y < Y_MIN) y = Y_MIN;
		return y[15:0];
	endfunction

	// Draws a sample weighted toward the table span and its boundaries.
	function automatic logic signed [15:0] rand_sample();
		logic signed [15:0] edges [13];
		edges = '{16'sd2047, 16'sd2048, 16'sd2049, -16'sd2047, -16'sd2048, -16'sd2049,
			16'sd1023, 16'sd1024, -16'sd1024, -16'sd1025, 16'sd0, -16'sd1, 16'sd1};
		case ($urandom_range(9))
			0, 1, 2, 3: return 16'($urandom);
			4, 5:       return $signed(16'($urandom_range(4095))) - 16'sd2048;
			6:          return $signed(16'($urandom_range(2047))) - 16'sd1024;
			7:          return edges[$urandom_range(12)];
			8:          return ($urandom_range(1) == 1) ? 16'sh7FFF - 16'($urandom_range(3))
				: 16'sh8000 + 16'($urandom_range(3));
			default:    return $signed(16'($urandom_range(511))) - 16'sd256;
		endcase
	endfunction

	task automatic flag_error(string msg);
		$display("ERROR at %0t ns: %s", $realtime, msg);
		err_count++;
	endtask

	// Holds start low until every expected result has come out.
	task automatic wait_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	// One APB write transfer followed by a read-back transfer of the same register.
	task automatic write_register(logic idx, logic [31:0] value);
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == nau_pkg::REG_ACT_MODE) begin
			cur_mode = value[2:0];
			readback = {29'd0, value[2:0]};
		end else begin
			cur_slope = value[15:0];
			readback = {16'd0, value[15:0]};
		end
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== readback) begin
			flag_error($sformatf("register %0d read back %0h, expected %0h",
				idx, prdata, readback));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Changes only the registers that differ, and only with nothing in flight.
	task automatic apply_config(logic [2:0] mode, logic [15:0] slope);
		if (mode != cur_mode || slope != cur_slope) begin
			wait_drain();
			if (mode != cur_mode) write_register(nau_pkg::REG_ACT_MODE, {29'd0, mode});
			if (slope != cur_slope) write_register(nau_pkg::REG_LEAK_SLOPE, {16'd0, slope});
		end
	endtask

	// Random sender gaps, then one input transfer; the expectation is queued
	// at the accepting edge.
	task automatic send_sample(logic signed [15:0] x, logic last, logic known,
			logic signed [15:0] y_known);
		act_result_t exp_res;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start   <= 1'b1;
		x_in    <= x;
		last_in <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		exp_res.y    = known ? y_known : activate(cur_mode, cur_slope, x);
		exp_res.last = last;
		pending_outputs.push_back(exp_res);
		samples_sent++;
	endtask

	// Result checker: every done strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		act_result_t exp_res;
		if (arst_n && done) begin
			if (pending_outputs.size() == 0) begin
				flag_error($sformatf("unexpected result y_out=%0d last_out=%0b",
					y_out, last_out));
			end else begin
				exp_res = pending_outputs.pop_front();
				results_checked++;
				if (y_out !== exp_res.y) begin
					flag_error($sformatf("y_out expected %0d, got %0d", exp_res.y, y_out));
				end
				if (last_out !== exp_res.last) begin
					flag_error($sformatf("last_out expected %0b, got %0b",
						exp_res.last, last_out));
				end
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no transfer of any kind.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready)) begin
			stall_count <= 0;
		end else if (stall_count >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	// Stimulus: directed table, then random segments with fresh register values.
	initial begin
		logic [2:0]  seg_mode;
		logic [15:0] seg_slope;
		build_sig_table();

		// mode, slope, x, last, known, expected y
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LINEAR, 16'd655, 16'sh7FFF,
			1'b1, 1'b1, 16'sh7FFF});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LINEAR, 16'd655, 16'sh8000,
			1'b0, 1'b1, 16'sh8000});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LEAKY, 16'd655, 16'sh8000,
			1'b1, 1'b1, -16'sd327});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LEAKY, 16'd655, -16'sd1,
			1'b0, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LEAKY, 16'd655, 16'sh7FFF,
			1'b0, 1'b1, 16'sh7FFF});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LEAKY, 16'd0, 16'sh8000,
			1'b0, 1'b1, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LEAKY, 16'hFFFF, 16'sh8000,
			1'b1, 1'b1, -16'sd32767});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_LEAKY, 16'hFFFF, -16'sd256,
			1'b0, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SIGMOID, 16'hFFFF, 16'sd0,
			1'b0, 1'b1, 16'sd128});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SIGMOID, 16'hFFFF, 16'sh7FFF,
			1'b1, 1'b1, 16'sd256});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SIGMOID, 16'hFFFF, 16'sh8000,
			1'b0, 1'b1, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SIGMOID, 16'hFFFF, 16'sd2047,
			1'b0, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SIGMOID, 16'hFFFF, 16'sd2048,
			1'b1, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SIGMOID, 16'hFFFF, -16'sd2049,
			1'b0, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_TANH, 16'hFFFF, 16'sd0,
			1'b0, 1'b1, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_TANH, 16'hFFFF, 16'sh7FFF,
			1'b0, 1'b1, 16'sd256});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_TANH, 16'hFFFF, 16'sh8000,
			1'b1, 1'b1, -16'sd256});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_TANH, 16'hFFFF, 16'sd1023,
			1'b0, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_TANH, 16'hFFFF, -16'sd1024,
			1'b0, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_RELU, 16'hFFFF, -16'sd1,
			1'b0, 1'b1, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_RELU, 16'hFFFF, 16'sh7FFF,
			1'b1, 1'b1, 16'sh7FFF});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_RELU, 16'hFFFF, 16'sh8000,
			1'b0, 1'b1, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SWISH, 16'hFFFF, 16'sh7FFF,
			1'b0, 1'b1, 16'sh7FFF});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SWISH, 16'hFFFF, 16'sh8000,
			1'b1, 1'b1, 16'sd0});
		dir_rows.push_back(stim_row_t'{nau_pkg::MODE_SWISH, 16'hFFFF, -16'sd300,
			1'b0, 1'b0, 16'sd0});
		dir_rows.push_back(stim_row_t'{MODE_UNDEF6, 16'hFFFF, 16'sh8000,
			1'b0, 1'b1, 16'sh8000});
		dir_rows.push_back(stim_row_t'{MODE_UNDEF7, 16'hFFFF, 16'sh7FFF,
			1'b1, 1'b1, 16'sh7FFF});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part from the reset register values; back to back while the registers stay unchanged.
		foreach (dir_rows[i]) begin
			apply_config(dir_rows[i].mode, dir_rows[i].slope);
			send_sample(dir_rows[i].x, dir_rows[i].last, dir_rows[i].known, dir_rows[i].y);
		end

		// Random part: each segment drains, rewrites both registers, then streams.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			idle_pct = (seg < 5) ? 17 : (seg < 10) ? 86 : 0;
			seg_mode = 3'(seg % 8);
			case ($urandom_range(3))
				0:       seg_slope = 16'h0000;
				1:       seg_slope = 16'hFFFF;
				2:       seg_slope = nau_pkg::LEAK_SLOPE_RESET;
				default: seg_slope = 16'($urandom);
			endcase
			wait_drain();
			write_register(nau_pkg::REG_ACT_MODE, {29'd0, seg_mode});
			write_register(nau_pkg::REG_LEAK_SLOPE, {16'd0, seg_slope});
			for (int n = 0; n < SEG_ITEMS; n++) begin
				send_sample(rand_sample(), 1'($urandom_range(1)), 1'b0, 16'sd0);
			end
		end

		wait_drain();
		repeat (LATENCY + 2) @(posedge clk);
		$display("Run covered %0d samples and %0d checked results across all eight mode codes,",
			samples_sent, results_checked);
		$display("slope extremes and three sender idle patterns.");
		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* neural_activation_unit.f */
rtl/nau_pkg.sv
rtl/nau_sigmoid.sv
rtl/neural_activation_unit.sv
tb/tb.sv
